// ----- design/rc_channel_light_controller_defines.svh -----
// Assertion macros used by the top-level design file.
`ifndef RC_CHANNEL_LIGHT_CONTROLLER_DEFINES_SVH
`define RC_CHANNEL_LIGHT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define RCLC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define RCLC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rclc_pkg.sv -----
package rclc_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int CODE_LEN      = 5;

    // Channel classification against the neutral zone.
    typedef enum logic [1:0] {
        DIR_LOW  = 2'd0,
        DIR_MID  = 2'd1,
        DIR_HIGH = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        CMD_LEFT    = 3'd0,
        CMD_CENTRE  = 3'd1,
        CMD_RIGHT   = 3'd2,
        CMD_FORWARD = 3'd3,
        CMD_STOP    = 3'd4,
        CMD_BACK    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        MOT_FRONT = 2'd0,
        MOT_BRAKE = 2'd1,
        MOT_BACK  = 2'd2,
        MOT_NONE  = 2'd3
    } motion_t;

    typedef enum logic [1:0] {
        BEEP_NONE = 2'd0,
        BEEP_HIGH = 2'd1,
        BEEP_LOW  = 2'd2
    } beep_t;

    typedef enum logic [1:0] {
        RBEEP_NONE  = 2'd0,
        RBEEP_START = 2'd1,
        RBEEP_STOP  = 2'd2
    } rbeep_t;

    typedef enum logic [1:0] {
        REG_DELTA_TRIGGER = 2'd0,
        REG_CENTER_WIDTH  = 2'd1,
        REG_DEAD_BAND     = 2'd2,
        REG_BLINK_PERIOD  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  delta_trigger;
        logic [11:0] center_width;
        logic [10:0] dead_band;
        logic [15:0] blink_period;
    } cfg_t;

    // Per-pass channel result: re-evaluated class differs from the held one,
    // and the class after this pass.
    typedef struct packed {
        logic changed;
        dir_t cls;
    } chan_evt_t;

    typedef struct packed {
        logic   left;
        logic   right;
        logic   brake;
        logic   reverse;
        beep_t  blink_beep;
        rbeep_t reverse_beep;
    } lamp_out_t;

    typedef cmd_t [HISTORY_DEPTH-1:0] hist_t;

    localparam cmd_t CODE_SEQ [CODE_LEN] = '{CMD_LEFT, CMD_RIGHT, CMD_LEFT, CMD_RIGHT,
                                             CMD_FORWARD};

    function automatic cmd_t steer_cmd(input dir_t d);
        cmd_t c;
        case (d)
            DIR_LOW:  c = CMD_RIGHT;
            DIR_HIGH: c = CMD_LEFT;
            default:  c = CMD_CENTRE;
        endcase
        return c;
    endfunction

    function automatic cmd_t throttle_cmd(input dir_t d);
        cmd_t c;
        case (d)
            DIR_LOW:  c = CMD_BACK;
            DIR_HIGH: c = CMD_FORWARD;
            default:  c = CMD_STOP;
        endcase
        return c;
    endfunction

endpackage

// ----- design/rclc_channel.sv -----
module rclc_channel (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [11:0]         width,
    input  rclc_pkg::cfg_t      cfg,
    output rclc_pkg::chan_evt_t evt
);

    logic signed [12:0] last_reg, last_next;
    rclc_pkg::dir_t     cls_reg, cls_next;

    logic signed [13:0] diff;
    logic        [13:0] abs_diff;
    logic signed [13:0] lo_bound;
    logic        [13:0] hi_bound;
    logic               eval;
    rclc_pkg::dir_t     new_dir;

    always_comb begin
        diff     = $signed({last_reg[12], last_reg}) - $signed({2'b00, width});
        abs_diff = diff[13] ? 14'(-diff) : 14'(diff);
        eval     = abs_diff >= {6'b0, cfg.delta_trigger};
        // lower bound may go negative: signed compare
        lo_bound = $signed({2'b00, cfg.center_width}) - $signed({3'b000, cfg.dead_band});
        hi_bound = {2'b00, cfg.center_width} + {3'b000, cfg.dead_band};
        if ($signed({2'b00, width}) < lo_bound) begin
            new_dir = rclc_pkg::DIR_LOW;
        end else if ({2'b00, width} > hi_bound) begin
            new_dir = rclc_pkg::DIR_HIGH;
        end else begin
            new_dir = rclc_pkg::DIR_MID;
        end
        evt.changed = eval && (new_dir != cls_reg);
        evt.cls     = evt.changed ? new_dir : cls_reg;
        last_next   = eval ? $signed({1'b0, width}) : last_reg;
        cls_next    = evt.cls;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= -13'sd1;
            cls_reg  <= rclc_pkg::DIR_MID;
        end else if (en) begin
            last_reg <= last_next;
            cls_reg  <= cls_next;
        end
    end

endmodule

// ----- design/rclc_history.sv -----
module rclc_history (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  rclc_pkg::chan_evt_t steer_evt,
    input  rclc_pkg::chan_evt_t throttle_evt,
    output logic                code_detected
);

    rclc_pkg::hist_t hist_reg, hist_next, hist_mid;
    logic            push_steer, push_throttle;
    logic            match_steer, match_throttle;

    function automatic rclc_pkg::hist_t shift_in(input rclc_pkg::hist_t h,
                                                 input rclc_pkg::cmd_t c);
        rclc_pkg::hist_t r;
        for (int i = rclc_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
            r[i] = h[i-1];
        end
        r[0] = c;
        return r;
    endfunction

    // newest entry at index 0, sequence oldest first
    function automatic logic seq_match(input rclc_pkg::hist_t h);
        logic m;
        m = 1'b1;
        for (int i = 0; i < rclc_pkg::CODE_LEN; i++) begin
            if (h[rclc_pkg::CODE_LEN-1-i] != rclc_pkg::CODE_SEQ[i]) begin
                m = 1'b0;
            end
        end
        return m;
    endfunction

    always_comb begin
        push_steer    = steer_evt.changed && (steer_evt.cls != rclc_pkg::DIR_MID);
        push_throttle = throttle_evt.changed && (throttle_evt.cls != rclc_pkg::DIR_MID);
        // steering goes in before throttle
        hist_mid  = push_steer ? shift_in(hist_reg, rclc_pkg::steer_cmd(steer_evt.cls))
                               : hist_reg;
        hist_next = push_throttle
                  ? shift_in(hist_mid, rclc_pkg::throttle_cmd(throttle_evt.cls))
                  : hist_mid;
        match_steer    = push_steer && seq_match(hist_mid);
        match_throttle = push_throttle && seq_match(hist_next);
        code_detected  = match_steer || match_throttle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= rclc_pkg::hist_t'({rclc_pkg::HISTORY_DEPTH{rclc_pkg::CMD_CENTRE}});
        end else if (en) begin
            hist_reg <= hist_next;
        end
    end

endmodule

// ----- design/rclc_lamp.sv -----
module rclc_lamp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  rclc_pkg::chan_evt_t steer_evt,
    input  rclc_pkg::chan_evt_t throttle_evt,
    input  logic [31:0]         now_ms,
    input  logic                effect_has_sound,
    input  logic [15:0]         blink_period,
    output rclc_pkg::lamp_out_t lamp
);

    rclc_pkg::dir_t    prior_reg [2];
    rclc_pkg::dir_t    prior_next [2];
    rclc_pkg::motion_t motion_reg, motion_next;
    logic [31:0]       blink_time_reg, blink_time_next;
    logic              phase_reg, phase_next;
    logic              left_on_reg, left_on_next;
    logic              right_on_reg, right_on_next;
    logic              reverse_on_reg, reverse_on_next;

    logic              quiet;
    logic              run;
    logic [31:0]       elapsed;
    rclc_pkg::beep_t   blink_beep;

    // throttle: prior commands and motion mode
    always_comb begin
        prior_next[0] = prior_reg[0];
        prior_next[1] = prior_reg[1];
        motion_next   = motion_reg;
        if (throttle_evt.changed) begin
            if (throttle_evt.cls != rclc_pkg::DIR_MID) begin
                prior_next[1] = prior_reg[0];
                prior_next[0] = throttle_evt.cls;
            end
            case (throttle_evt.cls)
                rclc_pkg::DIR_LOW: begin
                    motion_next = (prior_next[1] == rclc_pkg::DIR_HIGH)
                                ? rclc_pkg::MOT_BRAKE : rclc_pkg::MOT_BACK;
                end
                rclc_pkg::DIR_HIGH: begin
                    motion_next = rclc_pkg::MOT_FRONT;
                end
                default: begin
                    if (motion_reg != rclc_pkg::MOT_BRAKE && motion_reg != rclc_pkg::MOT_BACK) begin
                        motion_next = rclc_pkg::MOT_NONE;
                    end
                end
            endcase
        end
    end

    // blinker; both sides share one phase and one timestamp
    always_comb begin
        quiet           = reverse_on_reg || effect_has_sound;
        left_on_next    = left_on_reg;
        right_on_next   = right_on_reg;
        phase_next      = phase_reg;
        blink_time_next = blink_time_reg;
        run             = 1'b0;
        blink_beep      = rclc_pkg::BEEP_NONE;
        case (steer_evt.cls)
            rclc_pkg::DIR_HIGH: begin
                if (right_on_reg) begin
                    phase_next      = 1'b0;
                    blink_time_next = '0;
                end
                right_on_next = 1'b0;
                left_on_next  = 1'b1;
                run           = 1'b1;
            end
            rclc_pkg::DIR_LOW: begin
                if (left_on_reg) begin
                    phase_next      = 1'b0;
                    blink_time_next = '0;
                end
                left_on_next  = 1'b0;
                right_on_next = 1'b1;
                run           = 1'b1;
            end
            default: begin
                if (left_on_reg || right_on_reg) begin
                    phase_next      = 1'b0;
                    blink_time_next = '0;
                end
                left_on_next  = 1'b0;
                right_on_next = 1'b0;
            end
        endcase
        elapsed = now_ms - blink_time_next;
        if (run && (elapsed > {16'b0, blink_period})) begin
            blink_time_next = now_ms;
            phase_next      = !phase_next;
            if (!quiet) begin
                blink_beep = phase_next ? rclc_pkg::BEEP_HIGH : rclc_pkg::BEEP_LOW;
            end
        end
    end

    // reverse buzzer and lamp outputs
    always_comb begin
        reverse_on_next   = reverse_on_reg;
        lamp.reverse_beep = rclc_pkg::RBEEP_NONE;
        if (motion_next == rclc_pkg::MOT_BACK) begin
            if (!reverse_on_reg) begin
                reverse_on_next = 1'b1;
                if (!effect_has_sound) begin
                    lamp.reverse_beep = rclc_pkg::RBEEP_START;
                end
            end
        end else if (reverse_on_reg) begin
            reverse_on_next = 1'b0;
            if (!effect_has_sound) begin
                lamp.reverse_beep = rclc_pkg::RBEEP_STOP;
            end
        end
        lamp.blink_beep = blink_beep;
        lamp.left       = left_on_next && phase_next;
        lamp.right      = right_on_next && phase_next;
        lamp.brake      = motion_next == rclc_pkg::MOT_BRAKE;
        lamp.reverse    = reverse_on_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_reg[0]   <= rclc_pkg::DIR_MID;
            prior_reg[1]   <= rclc_pkg::DIR_MID;
            motion_reg     <= rclc_pkg::MOT_NONE;
            blink_time_reg <= '0;
            phase_reg      <= 1'b0;
            left_on_reg    <= 1'b0;
            right_on_reg   <= 1'b0;
            reverse_on_reg <= 1'b0;
        end else if (en) begin
            prior_reg[0]   <= prior_next[0];
            prior_reg[1]   <= prior_next[1];
            motion_reg     <= motion_next;
            blink_time_reg <= blink_time_next;
            phase_reg      <= phase_next;
            left_on_reg    <= left_on_next;
            right_on_reg   <= right_on_next;
            reverse_on_reg <= reverse_on_next;
        end
    end

endmodule

// ----- design/rc_channel_light_controller.sv -----
// RC channel light controller. Each input beat is one control pass carrying the
// steering and throttle pulse widths, the millisecond time and the effect-sound
// flag; each pass yields exactly one result beat with the blinker lamps, brake
// and reverse lamps, beep requests and the command-sequence pulse. The block
// takes one beat per clock unless the result side stalls it. A pass goes
// through an input register, one layer of compare/subtract logic (delta check,
// neutral-zone classification, history shift and five-entry match, 32-bit blink
// elapsed compare) and a result register, which offers the result beat.
// Backpressure on the result side stalls the pipe: while a finished result
// waits, the input register takes one more beat and then holds s_tready low
// until m_tready frees the result register. The user must write configuration
// through the plain write port while the block is idle; nothing enforces this.
`include "rc_channel_light_controller_defines.svh"

module rc_channel_light_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] steer_width, [23:12] throttle_width, [55:24] now_ms,
    // [56] effect_has_sound, [63:57] zero
    input  logic [63:0] s_tdata,
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] left_lamp, [1] right_lamp, [2] brake_lamp, [3] reverse_lamp,
    // [5:4] blink_beep, [7:6] reverse_beep, [8] code_detected, [15:9] zero
    output logic [15:0] m_tdata
);

    // configuration registers
    rclc_pkg::cfg_t cfg_reg;

    // input register
    logic        in_valid_reg;
    logic [11:0] steer_reg;
    logic [11:0] throttle_reg;
    logic [31:0] now_reg;
    logic        snd_reg;

    // result register
    logic        out_valid_reg;
    logic [8:0]  out_data_reg, out_data_next;

    logic                advance;   // pass moves from input to result register
    logic                in_take;
    rclc_pkg::chan_evt_t steer_evt;
    rclc_pkg::chan_evt_t throttle_evt;
    rclc_pkg::lamp_out_t lamp;
    logic                code_detected;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delta_trigger <= 8'd10;
            cfg_reg.center_width  <= 12'd1500;
            cfg_reg.dead_band     <= 11'd100;
            cfg_reg.blink_period  <= 16'd500;
        end else if (cfg_wr_en) begin
            case (rclc_pkg::cfg_idx_t'(cfg_wr_index))
                rclc_pkg::REG_DELTA_TRIGGER: cfg_reg.delta_trigger <= cfg_wr_data[7:0];
                rclc_pkg::REG_CENTER_WIDTH:  cfg_reg.center_width  <= cfg_wr_data[11:0];
                rclc_pkg::REG_DEAD_BAND:     cfg_reg.dead_band     <= cfg_wr_data[10:0];
                rclc_pkg::REG_BLINK_PERIOD:  cfg_reg.blink_period  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (in_take) begin
            steer_reg    <= s_tdata[11:0];
            throttle_reg <= s_tdata[23:12];
            now_reg      <= s_tdata[55:24];
            snd_reg      <= s_tdata[56];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    rclc_channel u_steer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .width   (steer_reg),
        .cfg     (cfg_reg),
        .evt     (steer_evt)
    );

    rclc_channel u_throttle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .width   (throttle_reg),
        .cfg     (cfg_reg),
        .evt     (throttle_evt)
    );

    rclc_history u_history (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .steer_evt     (steer_evt),
        .throttle_evt  (throttle_evt),
        .code_detected (code_detected)
    );

    rclc_lamp u_lamp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (advance),
        .steer_evt        (steer_evt),
        .throttle_evt     (throttle_evt),
        .now_ms           (now_reg),
        .effect_has_sound (snd_reg),
        .blink_period     (cfg_reg.blink_period),
        .lamp             (lamp)
    );

    assign out_data_next = {code_detected, lamp.reverse_beep, lamp.blink_beep,
                            lamp.reverse, lamp.brake, lamp.right, lamp.left};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg};

    // brake and back are exclusive motion modes
    `RCLC_ASSERT_IMP(a_lamps_excl, aclk, aresetn, out_valid_reg,
        !(out_data_reg[2] && out_data_reg[3]), "brake and reverse lamps both on")
    // one blinker side at a time
    `RCLC_ASSERT_IMP(a_blink_excl, aclk, aresetn, out_valid_reg,
        !(out_data_reg[0] && out_data_reg[1]), "left and right lamps both on")
    // a start request only comes with the reverse lamp lit
    `RCLC_ASSERT_IMP(a_rbeep_start, aclk, aresetn,
        out_valid_reg && (out_data_reg[7:6] == rclc_pkg::RBEEP_START),
        out_data_reg[3], "reverse start beep without reverse lamp")
    // input side only stalls when the pass is blocked
    `RCLC_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready, "input stalled without cause")
    `RCLC_ASSERT_NXT(a_advance_out, aclk, aresetn, advance, out_valid_reg,
        "pass advanced but no result held")

endmodule

// ----- test/rc_channel_light_controller_test.sv -----
`timescale 1ns / 100ps

// Beat-level check of the RC channel light controller: one input beat per
// control pass, one result beat back. A scoreboard model runs in step with
// the accepted input beats and every result beat is compared field by field.
module rc_channel_light_controller_test;
    import rclc_pkg::*;

    localparam int STALL_LIMIT  = 4000;   // cycles with no beat moving on either side
    localparam int HOLD_CYCLES  = 150;    // long receiver hold-off, fills the pipe
    localparam int PHASE_PASSES = 115;    // random passes per register setting
    localparam int RANDOM_PHASES = 7;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_LIGHT  = 1;
    localparam int RX_HEAVY  = 2;
    localparam int RX_TOGGLE = 3;

    // input beat, lowest field in the lowest bits
    typedef struct packed {
        logic        snd;
        logic [31:0] now;
        logic [11:0] throttle;
        logic [11:0] steer;
    } pass_t;

    // result beat, m_tdata[8:0]
    typedef struct packed {
        logic   code;
        rbeep_t rbeep;
        beep_t  bbeep;
        logic   reverse;
        logic   brake;
        logic   right;
        logic   left;
    } lights_t;

    // directed row; 'fixed' rows carry a hand-typed result
    typedef struct {
        logic [11:0] steer;
        logic [11:0] throttle;
        logic [31:0] now;
        logic        snd;
        logic        fixed;
        lights_t     lights;
    } row_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [1:0]  cfg_wr_index = 2'd0;
    logic [15:0] cfg_wr_data  = 16'd0;
    logic        s_tvalid     = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata      = 64'd0;
    logic        m_tvalid;
    logic        m_tready     = 1'b0;
    logic [15:0] m_tdata;

    rc_channel_light_controller u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Light model: its own copy of registers and channel/blinker state
    // ------------------------------------------------------------------
    logic [7:0]  cfg_delta;
    logic [11:0] cfg_center;
    logic [10:0] cfg_dead;
    logic [15:0] cfg_period;

    int          last_steer_w, last_thr_w;   // -1 after reset: first pass re-evaluates unless width + 1 is under delta
    cmd_t        steer_cls, thr_cls;
    cmd_t        prior_thr [2];              // [0] newest non-stop throttle command
    cmd_t        cmd_hist [HISTORY_DEPTH];   // [0] newest
    motion_t     motion;
    logic [31:0] blink_stamp;
    logic        blink_phase, blink_l, blink_r, brake_on, rev_on;

    task automatic model_reset();
        cfg_delta    = 8'd10;
        cfg_center   = 12'd1500;
        cfg_dead     = 11'd100;
        cfg_period   = 16'd500;
        last_steer_w = -1;
        last_thr_w   = -1;
        steer_cls    = CMD_CENTRE;
        thr_cls      = CMD_STOP;
        prior_thr[0] = CMD_STOP;
        prior_thr[1] = CMD_STOP;
        foreach (cmd_hist[i]) cmd_hist[i] = CMD_CENTRE;
        motion       = MOT_NONE;
        blink_stamp  = 32'd0;
        blink_phase  = 1'b0;
        blink_l      = 1'b0;
        blink_r      = 1'b0;
        brake_on     = 1'b0;
        rev_on       = 1'b0;
    endtask

    // signed bounds: a negative lower bound leaves nothing below it
    function automatic dir_t zone_of(int w);
        if (w < int'(cfg_center) - int'(cfg_dead)) return DIR_LOW;
        if (w > int'(cfg_center) + int'(cfg_dead)) return DIR_HIGH;
        return DIR_MID;
    endfunction

    // shift a command in and look for left, right, left, right, forward
    function automatic logic hist_push(cmd_t c);
        logic hit;
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) cmd_hist[i] = cmd_hist[i - 1];
        cmd_hist[0] = c;
        hit = 1'b1;
        for (int i = 0; i < CODE_LEN; i++)
            if (cmd_hist[CODE_LEN - 1 - i] != CODE_SEQ[i]) hit = 1'b0;
        return hit;
    endfunction

    function automatic lights_t light_pass(pass_t p);
        lights_t r;
        int      d;
        cmd_t    c;
        logic    code;
        beep_t   bb;
        rbeep_t  rb;
        code = 1'b0;
        bb   = BEEP_NONE;
        rb   = RBEEP_NONE;

        // steering first, so a steer push lands before a throttle push
        d = last_steer_w - int'(p.steer);
        if (d < 0) d = -d;
        if (d >= int'(cfg_delta)) begin
            case (zone_of(int'(p.steer)))
                DIR_LOW:  c = CMD_RIGHT;
                DIR_HIGH: c = CMD_LEFT;
                default:  c = CMD_CENTRE;
            endcase
            last_steer_w = int'(p.steer);
            if (c != steer_cls) begin
                steer_cls = c;
                if (c != CMD_CENTRE) begin
                    if (hist_push(c)) code = 1'b1;
                end
            end
        end

        d = last_thr_w - int'(p.throttle);
        if (d < 0) d = -d;
        if (d >= int'(cfg_delta)) begin
            case (zone_of(int'(p.throttle)))
                DIR_LOW:  c = CMD_BACK;
                DIR_HIGH: c = CMD_FORWARD;
                default:  c = CMD_STOP;
            endcase
            last_thr_w = int'(p.throttle);
            if (c != thr_cls) begin
                thr_cls = c;
                if (c != CMD_STOP) begin
                    prior_thr[1] = prior_thr[0];
                    prior_thr[0] = c;
                    if (hist_push(c)) code = 1'b1;
                end
                // reverse straight after forward brakes; stop keeps brake/back
                if (c == CMD_BACK)
                    motion = (prior_thr[1] == CMD_FORWARD) ? MOT_BRAKE : MOT_BACK;
                else if (c == CMD_FORWARD)
                    motion = MOT_FRONT;
                else if (motion != MOT_BRAKE && motion != MOT_BACK)
                    motion = MOT_NONE;
            end
        end

        // dropping an active blinker clears the shared phase and its timestamp
        if (steer_cls != CMD_RIGHT && blink_r) begin
            blink_r     = 1'b0;
            blink_phase = 1'b0;
            blink_stamp = 32'd0;
        end
        if (steer_cls != CMD_LEFT && blink_l) begin
            blink_l     = 1'b0;
            blink_phase = 1'b0;
            blink_stamp = 32'd0;
        end
        if (steer_cls == CMD_LEFT || steer_cls == CMD_RIGHT) begin
            if (steer_cls == CMD_LEFT) blink_l = 1'b1;
            else blink_r = 1'b1;
            // elapsed time wraps mod 2^32; period 0 toggles on any progress
            if (p.now - blink_stamp > {16'd0, cfg_period}) begin
                blink_stamp = p.now;
                blink_phase = ~blink_phase;
                // tick beep only if reverse lamp was off before this pass and no effect sound
                if (!(rev_on || p.snd)) bb = blink_phase ? BEEP_HIGH : BEEP_LOW;
            end
        end

        brake_on = (motion == MOT_BRAKE);
        if (motion == MOT_BACK) begin
            if (!rev_on) begin
                rev_on = 1'b1;
                if (!p.snd) rb = RBEEP_START;
            end
        end else if (rev_on) begin
            rev_on = 1'b0;
            if (!p.snd) rb = RBEEP_STOP;
        end

        r.left    = blink_l & blink_phase;
        r.right   = blink_r & blink_phase;
        r.brake   = brake_on;
        r.reverse = rev_on;
        r.bbeep   = bb;
        r.rbeep   = rb;
        r.code    = code;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    lights_t lights_due_q [$];
    lights_t typed_lights [int];   // hand-typed results keyed by input beat number
    lights_t lights_seen, lights_due;
    int      passes_in   = 0;
    int      passes_out  = 0;      // results compared
    int      errors      = 0;
    int      stall_count = 0;
    int      n_match = 0, n_brake = 0, n_reverse = 0, n_beep = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch, result %0d: %s got %0d expected %0d", passes_out, what, got, want);
        errors++;
    endtask

    // All sampling happens on the rising edge, reading pre-edge values.
    always @(posedge aclk) begin
        if (!aresetn) begin
            model_reset();
        end else begin
            // register writes only happen while idle, so order vs. beats is moot
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_wr_index))
                    REG_DELTA_TRIGGER: cfg_delta  = cfg_wr_data[7:0];
                    REG_CENTER_WIDTH:  cfg_center = cfg_wr_data[11:0];
                    REG_DEAD_BAND:     cfg_dead   = cfg_wr_data[10:0];
                    default:           cfg_period = cfg_wr_data;
                endcase
            end

            if (s_tvalid && s_tready) begin
                lights_due = light_pass(pass_t'(s_tdata[56:0]));
                if (typed_lights.exists(passes_in)) lights_due = typed_lights[passes_in];
                lights_due_q.push_back(lights_due);
                passes_in++;
            end

            if (m_tvalid && m_tready) begin
                lights_seen = lights_t'(m_tdata[8:0]);
                if (lights_due_q.size() == 0) begin
                    report_mismatch("result with no pass waiting", int'(m_tdata), 0);
                end else begin
                    lights_due = lights_due_q.pop_front();
                    if (lights_seen.left !== lights_due.left)
                        report_mismatch("left_lamp", lights_seen.left, lights_due.left);
                    if (lights_seen.right !== lights_due.right)
                        report_mismatch("right_lamp", lights_seen.right, lights_due.right);
                    if (lights_seen.brake !== lights_due.brake)
                        report_mismatch("brake_lamp", lights_seen.brake, lights_due.brake);
                    if (lights_seen.reverse !== lights_due.reverse)
                        report_mismatch("reverse_lamp", lights_seen.reverse,
                                        lights_due.reverse);
                    if (lights_seen.bbeep !== lights_due.bbeep)
                        report_mismatch("blink_beep", int'(lights_seen.bbeep),
                                        int'(lights_due.bbeep));
                    if (lights_seen.rbeep !== lights_due.rbeep)
                        report_mismatch("reverse_beep", int'(lights_seen.rbeep),
                                        int'(lights_due.rbeep));
                    if (lights_seen.code !== lights_due.code)
                        report_mismatch("code_detected", lights_seen.code, lights_due.code);
                    n_match   += lights_due.code;
                    n_brake   += lights_due.brake;
                    n_reverse += lights_due.reverse;
                    n_beep    += (lights_due.bbeep != BEEP_NONE);
                    passes_out++;
                end
            end

            // watchdog: nothing moved for too long
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_count = 0;
            else stall_count++;
            if (stall_count == STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: rotating stall patterns, plus a long hold-off on request
    // ------------------------------------------------------------------
    int hold_req  = 0;   // bumped by the stimulus side
    int hold_seen = 0;
    int hold_left = 0;
    int rx_mode   = RX_OPEN;
    int rx_span   = 0;

    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode <= $urandom_range(RX_OPEN, RX_TOGGLE);
                rx_span <= $urandom_range(8, 64);
            end else begin
                rx_span <= rx_span - 1;
            end
            case (rx_mode)
                RX_OPEN:  m_tready <= 1'b1;
                RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: m_tready <= ($urandom_range(0, 2) == 0);
                default:  m_tready <= ~m_tready;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    int          passes_sent = 0;
    int          burst_left  = 0;
    int          settings    = 0;
    logic [11:0] drv_center  = 12'd1500;
    logic [10:0] drv_dead    = 11'd100;
    logic [31:0] clock_ms    = 32'd0;
    logic [11:0] prev_sw     = 12'd1500;
    logic [11:0] prev_tw     = 12'd1500;

    // Offer one beat; returns on the edge that took it. s_tready only moves
    // on rising edges, so its value at the falling edge is what the edge sees.
    task automatic offer_beat(pass_t p);
        logic took;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, p};
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        passes_sent++;
    endtask

    // drain the pipe before touching registers
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (passes_out < passes_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(logic [7:0] d, logic [11:0] c, logic [10:0] b, logic [15:0] p);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_DELTA_TRIGGER;
        cfg_wr_data  <= {8'd0, d};
        @(posedge aclk);
        cfg_wr_index <= REG_CENTER_WIDTH;
        cfg_wr_data  <= {4'd0, c};
        @(posedge aclk);
        cfg_wr_index <= REG_DEAD_BAND;
        cfg_wr_data  <= {5'd0, b};
        @(posedge aclk);
        cfg_wr_index <= REG_BLINK_PERIOD;
        cfg_wr_data  <= p;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        drv_center = c;
        drv_dead   = b;
        settings++;
    endtask

    // width inside the wanted zone for the current setting, if there is one
    function automatic logic [11:0] pick_width(dir_t d);
        int lo, hi;
        lo = int'(drv_center) - int'(drv_dead);
        hi = int'(drv_center) + int'(drv_dead);
        case (d)
            DIR_LOW:  if (lo > 0) return 12'($urandom_range(0, lo - 1));
            DIR_HIGH: if (hi < 4095) return 12'($urandom_range(hi + 1, 4095));
            default:  return 12'($urandom_range(lo < 0 ? 0 : lo, hi > 4095 ? 4095 : hi));
        endcase
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [11:0] any_width(logic [11:0] prev);
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 4095);
            1:       v = int'(prev) + int'($urandom_range(0, 30)) - 15;   // jitter near delta
            default: v = $urandom_range(0, 3000);
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    task automatic step_pass(logic [11:0] sw, logic [11:0] tw);
        pass_t p;
        case ($urandom_range(0, 19))
            0:       clock_ms = $urandom;                  // jump anywhere, wraps too
            1:       ;                                     // same millisecond
            2, 3, 4: clock_ms += $urandom_range(300, 2000);
            default: clock_ms += $urandom_range(1, 300);
        endcase
        p.steer    = sw;
        p.throttle = tw;
        p.now      = clock_ms;
        p.snd      = ($urandom_range(0, 4) == 0);
        prev_sw    = sw;
        prev_tw    = tw;
        offer_beat(p);
    endtask

    // left, right, left, right, then forward; sometimes one step is spoiled.
    // Steering above centre is left.
    task automatic play_gesture();
        dir_t        steer_dirs [4];
        int          broken;
        logic [11:0] sw;
        steer_dirs = '{DIR_HIGH, DIR_LOW, DIR_HIGH, DIR_LOW};
        broken = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 4)) : -1;
        sw = pick_width(DIR_MID);
        step_pass(sw, pick_width(DIR_MID));
        for (int i = 0; i < 4; i++) begin
            sw = pick_width(i == broken ? dir_t'($urandom_range(0, 2)) : steer_dirs[i]);
            step_pass(sw, pick_width(DIR_MID));
        end
        step_pass(sw, pick_width(broken == 4 ? DIR_LOW : DIR_HIGH));
    endtask

    // throttle moves under a held steering class: forward/reverse/stop mixes
    task automatic play_drive();
        logic [11:0] sw;
        sw = pick_width(dir_t'($urandom_range(0, 2)));
        repeat ($urandom_range(3, 6)) step_pass(sw, pick_width(dir_t'($urandom_range(0, 2))));
    endtask

    // Directed rows, reset register values (delta 10, centre 1500, band 100,
    // period 500). Only the first two results are typed in.
    row_t script [24] = '{
        // neutral after reset: nothing lit
        '{12'd1500, 12'd1500, 32'h0000_0000, 1'b0, 1'b1,
          '{1'b0, RBEEP_NONE, BEEP_NONE, 1'b0, 1'b0, 1'b0, 1'b0}},
        // both at zero: right blinker at phase 0, reverse lamp with start beep
        '{12'd0, 12'd0, 32'h0000_0000, 1'b0, 1'b1,
          '{1'b0, RBEEP_START, BEEP_NONE, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{12'd4095, 12'd4095, 32'd1000, 1'b0, 1'b0, '0},   // top widths, blink quiet
        '{12'd1500, 12'd1500, 32'd1100, 1'b0, 1'b0, '0},   // blinker off clears phase
        '{12'd2000, 12'd1500, 32'd1200, 1'b0, 1'b0, '0},   // code sequence
        '{12'd1000, 12'd1500, 32'd1300, 1'b0, 1'b0, '0},
        '{12'd2000, 12'd1500, 32'd1400, 1'b0, 1'b0, '0},
        '{12'd1000, 12'd1500, 32'd1500, 1'b0, 1'b0, '0},
        '{12'd1000, 12'd2000, 32'd1600, 1'b0, 1'b0, '0},   // forward completes it
        '{12'd1000, 12'd1000, 32'd1700, 1'b0, 1'b0, '0},   // reverse after forward: brake
        '{12'd1000, 12'd1500, 32'd1800, 1'b0, 1'b0, '0},   // stop holds brake
        '{12'd1004, 12'd1495, 32'd1810, 1'b0, 1'b0, '0},   // under delta: ignored
        '{12'd1000, 12'd1000, 32'd2600, 1'b1, 1'b0, '0},   // back, sound muted
        '{12'd1000, 12'd1500, 32'd3200, 1'b0, 1'b0, '0},   // stop holds back
        '{12'd2000, 12'd1500, 32'd3300, 1'b0, 1'b0, '0},   // sequence again, last
        '{12'd1000, 12'd1500, 32'd3400, 1'b0, 1'b0, '0},   // step moves both
        '{12'd2000, 12'd1500, 32'd3500, 1'b0, 1'b0, '0},   // channels at once
        '{12'd1000, 12'd2000, 32'd3600, 1'b0, 1'b0, '0},
        '{12'd1500, 12'd1500, 32'hFFFF_FF00, 1'b0, 1'b0, '0},
        '{12'd2000, 12'd1500, 32'hFFFF_FFF0, 1'b0, 1'b0, '0},   // toggle near the wrap
        '{12'd2000, 12'd1500, 32'h0000_0100, 1'b0, 1'b0, '0},   // wrapped, still short
        '{12'd2000, 12'd1500, 32'h0000_0300, 1'b0, 1'b0, '0},   // wrapped, long enough
        '{12'd2000, 12'd1500, 32'h0000_0600, 1'b1, 1'b0, '0},   // toggle, muted
        '{12'd4095, 12'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0}
    };

    initial begin : stimulus
        pass_t p;
        int    phase_start;
        int    kind;
        logic  held;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        for (int i = 0; i < $size(script); i++) begin
            if (script[i].fixed) typed_lights[passes_sent] = script[i].lights;
            p.steer    = script[i].steer;
            p.throttle = script[i].throttle;
            p.now      = script[i].now;
            p.snd      = script[i].snd;
            prev_sw    = p.steer;
            prev_tw    = p.throttle;
            offer_beat(p);
        end
        clock_ms = 32'h0000_0600;

        // random passes, one register setting per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0: set_config(8'd10, 12'd1500, 11'd100, 16'd500);
                1: set_config(8'd0, 12'd0, 11'd0, 16'd0);            // every nonzero width above band
                2: set_config(8'd255, 12'd4095, 11'd2047, 16'd65535);
                3: set_config(8'd255, 12'd3000, 11'd1500, 16'd1);
                5: set_config(8'd1, 12'd1500, 11'd0, 16'd65535);
                default: set_config(8'($urandom_range(0, 40)), 12'($urandom_range(1200, 1800)),
                                    11'($urandom_range(20, 300)), 16'($urandom_range(1, 300)));
            endcase
            phase_start = passes_sent;
            held = 1'b0;
            while (passes_sent < phase_start + PHASE_PASSES) begin
                kind = $urandom_range(0, 9);
                if (kind < 5) play_gesture();
                else if (kind < 7) play_drive();
                else step_pass(any_width(prev_sw), any_width(prev_tw));
                // long receiver hold-off while beats keep coming
                if ((ph == 0 || ph == 4) && !held && passes_sent > phase_start + 20) begin
                    hold_req <= hold_req + 1;
                    held = 1'b1;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (passes_out < passes_sent) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (lights_due_q.size() != 0)
            report_mismatch("results never delivered", lights_due_q.size(), 0);

        $display("%0d control passes checked under %0d register settings", passes_out,
                 settings + 1);
        $display("%0d sequence matches, %0d brake, %0d reverse, %0d blinker beeps", n_match,
                 n_brake, n_reverse, n_beep);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
